### rtl/core/skf_pkg.sv
// Shared types, constants and microcode program of the scalar Kalman filter unit.
`default_nettype none

package skf_pkg;

	localparam int MEAS_W    = 32;
	localparam int INNOV_W   = MEAS_W + 1;
	localparam int REG_W     = 24;
	localparam int COV_W     = 25;
	localparam int CFG_IDX_W = 2;
	localparam int MUL_SPLIT = 16;
	localparam int STEP_W    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COVARIANCE = 2'd2;

	localparam logic [REG_W-1:0] PROCESS_NOISE_RST      = 24'd98304;
	localparam logic [REG_W-1:0] MEASUREMENT_NOISE_RST  = 24'd131072;
	localparam logic [REG_W-1:0] INITIAL_COVARIANCE_RST = 24'd131072;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [3:0] {
		OP_LOAD,
		OP_PRED,
		OP_DENOM,
		OP_DIV,
		OP_GAIN,
		OP_MUL_P,
		OP_COV,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_ACC,
		OP_EST
	} op_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_WAIT_IN,
		JMP_LOOP,
		JMP_WAIT_OUT
	} jmp_t;

	typedef struct packed {
		op_t   op;
		jmp_t  jmp;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		logic in_fire;
		logic loop_more;
		logic out_free;
	} seq_status_t;

	localparam step_t STEP_LOAD = 4'd0;
	localparam step_t STEP_DIV  = 4'd3;

	function automatic ctrl_word_t prog_word(step_t s);
		ctrl_word_t w;
		case (s)
			4'd0:    w = '{op: OP_LOAD,   jmp: JMP_WAIT_IN,  target: STEP_LOAD};
			4'd1:    w = '{op: OP_PRED,   jmp: JMP_NEXT,     target: STEP_LOAD};
			4'd2:    w = '{op: OP_DENOM,  jmp: JMP_NEXT,     target: STEP_LOAD};
			4'd3:    w = '{op: OP_DIV,    jmp: JMP_LOOP,     target: STEP_DIV};
			4'd4:    w = '{op: OP_GAIN,   jmp: JMP_NEXT,     target: STEP_LOAD};
			4'd5:    w = '{op: OP_MUL_P,  jmp: JMP_NEXT,     target: STEP_LOAD};
			4'd6:    w = '{op: OP_COV,    jmp: JMP_NEXT,     target: STEP_LOAD};
			4'd7:    w = '{op: OP_MUL_LO, jmp: JMP_NEXT,     target: STEP_LOAD};
			4'd8:    w = '{op: OP_MUL_HI, jmp: JMP_NEXT,     target: STEP_LOAD};
			4'd9:    w = '{op: OP_ACC,    jmp: JMP_NEXT,     target: STEP_LOAD};
			4'd10:   w = '{op: OP_EST,    jmp: JMP_WAIT_OUT, target: STEP_LOAD};
			default: w = '{op: OP_LOAD,   jmp: JMP_WAIT_IN,  target: STEP_LOAD};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### rtl/core/skf_seq.sv
// Microcode sequencer: step counter, program table lookup and jump logic.
`default_nettype none

module skf_seq
	import skf_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  seq_status_t status,
	output ctrl_word_t  ctrl
);

	step_t step_q;
	step_t step_d;

	assign ctrl = prog_word(step_q);

	always_comb begin
		step_d = step_q;
		case (ctrl.jmp)
			JMP_NEXT:     step_d = step_q + step_t'(1);
			JMP_WAIT_IN:  step_d = status.in_fire ? step_q + step_t'(1) : step_q;
			JMP_LOOP:     step_d = status.loop_more ? ctrl.target : step_q + step_t'(1);
			JMP_WAIT_OUT: step_d = status.out_free ? ctrl.target : step_q;
			default:      step_d = STEP_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_LOAD;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/scalar_kalman_filter_unit.sv
// Scalar Kalman filter unit: config registers, filter state and microcoded datapath.
// One sample is handled at a time: a new input is taken only after the previous estimate
// has gone to the result register, and that step waits while a result is still untaken.
// A restoring divider produces the gain, one gain bit per cycle.
// Reset: config registers take their defaults, estimate clears, covariance loads
// the initial value and the next sample reloads both as the first sample.
`default_nettype none

module scalar_kalman_filter_unit
	import skf_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [MEAS_W-1:0]    s_tdata,   // [31:0] measurement
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [MEAS_W-1:0]    m_tdata,   // [31:0] estimate
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [REG_W-1:0]     cfg_data
);

	localparam int GAIN_W = FRAC_BITS;
	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int CNT_W  = $clog2(FRAC_BITS + 1);
	localparam int DEN_W  = COV_W + 1;
	localparam int REM_W  = DEN_W + 1;
	localparam int MULA_W = GAIN_W + 1;
	localparam int MULB_W = COV_W + 1;
	localparam int MUL_W  = MULA_W + MULB_W;
	localparam int ACC_W  = GAIN_W + INNOV_W + 1;
	localparam int SHF_W  = ACC_W - FRAC_BITS;
	localparam int RED_W  = MUL_W - FRAC_BITS;
	localparam int SUM_W  = MEAS_W + 3;

	ctrl_word_t  ctrl;
	seq_status_t status;

	logic [REG_W-1:0] q_noise_q;
	logic [REG_W-1:0] r_noise_q;
	logic [REG_W-1:0] p_init_q;

	logic                      first_q;
	logic signed [MEAS_W-1:0]  est_q;
	logic [COV_W-1:0]          cov_q;
	logic                      out_valid_q;
	logic [MEAS_W-1:0]         out_data_q;

	logic signed [MEAS_W-1:0]  meas_q;
	logic signed [INNOV_W-1:0] innov_q;
	logic [COV_W-1:0]          pred_q;
	logic [DEN_W-1:0]          den_q;
	logic [REM_W-1:0]          rem_q;
	logic [QUO_W-1:0]          quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [GAIN_W-1:0]         gain_q;
	logic signed [MUL_W-1:0]   mul_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic                      in_fire;
	logic                      out_free;
	logic [DEN_W-1:0]          pred_sum;
	logic                      div_ge;
	logic [REM_W-1:0]          rem_sub;
	logic signed [MULA_W-1:0]  mul_a;
	logic signed [MULB_W-1:0]  mul_b;
	logic signed [MUL_W-1:0]   mul_p;
	logic [RED_W-1:0]          reduce;
	logic [RED_W-1:0]          pred_ext;
	logic [RED_W-1:0]          cov_diff;
	logic signed [SHF_W-1:0]   est_step;
	logic signed [SUM_W-1:0]   est_sum;
	logic signed [MEAS_W-1:0]  est_sat;

	skf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign s_tready  = (ctrl.op == OP_LOAD);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign cfg_ready = 1'b1;

	assign status = '{in_fire: in_fire, loop_more: (cnt_q != '0), out_free: out_free};

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= PROCESS_NOISE_RST;
			r_noise_q <= MEASUREMENT_NOISE_RST;
			p_init_q  <= INITIAL_COVARIANCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROCESS_NOISE:      q_noise_q <= cfg_data;
				REG_MEASUREMENT_NOISE:  r_noise_q <= cfg_data;
				REG_INITIAL_COVARIANCE: p_init_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// datapath arithmetic
	assign pred_sum = {1'b0, cov_q} + {2'b00, q_noise_q};
	assign div_ge   = (rem_q >= {1'b0, den_q});
	assign rem_sub  = div_ge ? rem_q - {1'b0, den_q} : rem_q;

	assign mul_a = signed'({1'b0, gain_q});
	always_comb begin
		case (ctrl.op)
			OP_MUL_P:  mul_b = signed'({1'b0, pred_q});
			OP_MUL_LO: mul_b = signed'({{(MULB_W - MUL_SPLIT){1'b0}},
				innov_q[MUL_SPLIT-1:0]});
			default:   mul_b = signed'({{(MULB_W - (INNOV_W - MUL_SPLIT)){innov_q[INNOV_W-1]}},
				innov_q[INNOV_W-1:MUL_SPLIT]});
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign reduce   = mul_q[MUL_W-1:FRAC_BITS];
	assign pred_ext = RED_W'(pred_q);
	assign cov_diff = pred_ext - reduce;

	assign est_step = acc_q[ACC_W-1:FRAC_BITS];
	assign est_sum  = SUM_W'(est_q) + SUM_W'(est_step);
	always_comb begin
		if (est_sum[SUM_W-1:MEAS_W-1] == '0 || est_sum[SUM_W-1:MEAS_W-1] == '1) begin
			est_sat = est_sum[MEAS_W-1:0];
		end else if (est_sum[SUM_W-1]) begin
			est_sat = {1'b1, {(MEAS_W - 1){1'b0}}};
		end else begin
			est_sat = {1'b0, {(MEAS_W - 1){1'b1}}};
		end
	end

	// filter state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= 1'b1;
			est_q       <= '0;
			cov_q       <= COV_W'(INITIAL_COVARIANCE_RST);
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire && first_q) begin
				first_q <= 1'b0;
				est_q   <= s_tdata;
				cov_q   <= COV_W'(p_init_q);
			end
			if (ctrl.op == OP_COV) begin
				cov_q <= (reduce > pred_ext) ? '0 : cov_diff[COV_W-1:0];
			end
			if (ctrl.op == OP_EST && out_free) begin
				est_q       <= est_sat;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (in_fire) begin
					meas_q <= s_tdata;
				end
			end
			OP_PRED: begin
				pred_q  <= pred_sum[COV_W] ? '1 : pred_sum[COV_W-1:0];
				innov_q <= INNOV_W'(meas_q) - INNOV_W'(est_q);
			end
			OP_DENOM: begin
				den_q <= {1'b0, pred_q} + {2'b00, r_noise_q};
				rem_q <= {2'b00, pred_q};
				quo_q <= '0;
				cnt_q <= CNT_W'(FRAC_BITS);
			end
			OP_DIV: begin
				quo_q <= {quo_q[QUO_W-2:0], div_ge};
				rem_q <= {rem_sub[REM_W-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			OP_GAIN: begin
				if (den_q == '0) begin
					gain_q <= '0;
				end else if (quo_q[QUO_W-1]) begin
					gain_q <= '1;
				end else begin
					gain_q <= quo_q[GAIN_W-1:0];
				end
			end
			OP_MUL_P, OP_MUL_LO: begin
				mul_q <= mul_p;
			end
			OP_MUL_HI: begin
				acc_q <= ACC_W'(mul_q);
				mul_q <= mul_p;
			end
			OP_ACC: begin
				acc_q <= acc_q + (ACC_W'(mul_q) <<< MUL_SPLIT);
			end
			OP_EST: begin
				if (out_free) begin
					out_data_q <= est_sat;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_out_from_est: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.op == OP_EST))
		else $error("result valid raised outside the estimate step");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (ctrl.op == OP_PRED))
		else $error("accepted sample did not start the program");

	a_first_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(first_q) |-> $past(in_fire))
		else $error("first-sample flag cleared without a transfer");

	a_div_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_DIV && den_q != '0) |=> (rem_q < {den_q, 1'b0}))
		else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire
